// File: rtl/ucmc_pkg.sv
// Shared types, codes and constants of the UPS charge-mode controller.
package ucmc_pkg;

   localparam int CFG_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int SAMPLE_W = 10;
   localparam int TENTHS_W = 8;
   localparam logic [10:0] ADC_FULL_CODE = 11'd1023;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_POWER_FAIL = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_FAST = 2'd1;
   localparam logic [1:0] MODE_FLOAT = 2'd2;
   localparam logic [1:0] MODE_DEAD = 2'd3;

   localparam logic [1:0] PHASE_CODE_WAIT = 2'd0;
   localparam logic [1:0] PHASE_CODE_DELAY = 2'd1;
   localparam logic [1:0] PHASE_CODE_RUN = 2'd2;
   localparam logic [1:0] PHASE_CODE_HALT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_TICKS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOAT_ENTER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOAT_HOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_LEVEL = 3'd4;

   typedef enum logic [3:0] {
      PH_WAIT  = 4'b0001,
      PH_DELAY = 4'b0010,
      PH_RUN   = 4'b0100,
      PH_HALT  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic ac_online;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic relay_on;
      logic charge_control;
      logic led_fast;
      logic led_float;
      logic [1:0] mode;
      logic [7:0] average_tenths;
      logic average_valid;
      logic [1:0] phase;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] startup_ticks;
      logic [CFG_W-1:0] full_scale_tenths;
      logic [CFG_W-1:0] float_enter_level;
      logic [CFG_W-1:0] float_hold_level;
      logic [CFG_W-1:0] dead_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic ac_online;
      logic [TENTHS_W-1:0] tenths;
   } stage_type;

   function automatic logic [1:0] phase_code(phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_WAIT:  code = PHASE_CODE_WAIT;
         PH_DELAY: code = PHASE_CODE_DELAY;
         PH_RUN:   code = PHASE_CODE_RUN;
         PH_HALT:  code = PHASE_CODE_HALT;
         default:  code = PHASE_CODE_WAIT;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/ucmc_csr.sv
// Configuration registers of the UPS charge-mode controller.
module ucmc_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [ucmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ucmc_pkg::CFG_W-1:0] csr_write_data,
   output ucmc_pkg::cfg_type cfg
);
   import ucmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STARTUP_TICKS: cfg_in.startup_ticks = csr_write_data;
            CSR_FULL_SCALE:    cfg_in.full_scale_tenths = csr_write_data;
            CSR_FLOAT_ENTER:   cfg_in.float_enter_level = csr_write_data;
            CSR_FLOAT_HOLD:    cfg_in.float_hold_level = csr_write_data;
            CSR_DEAD_LEVEL:    cfg_in.dead_level = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_ticks <= 8'd3;
         cfg_ff.full_scale_tenths <= 8'd160;
         cfg_ff.float_enter_level <= 8'd130;
         cfg_ff.float_hold_level <= 8'd125;
         cfg_ff.dead_level <= 8'd80;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ucmc_scale.sv
// Input register with ADC code to tenths-of-a-volt scaling.
module ucmc_scale (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ucmc_pkg::req_type req_data,
   input  logic [ucmc_pkg::CFG_W-1:0] full_scale_tenths,
   input  logic advance,
   output logic stage_valid,
   output ucmc_pkg::stage_type stage_data
);
   import ucmc_pkg::*;

   logic stage_valid_ff;
   logic stage_valid_in;
   stage_type stage_data_ff;
   stage_type stage_data_in;
   logic take;
   logic [17:0] product;
   logic [7:0] quot_low;
   logic [10:0] remainder;
   logic [TENTHS_W-1:0] tenths;

   // divide by 1023: quotient is product/1024 plus at most one
   assign product = {10'd0, full_scale_tenths} * {8'd0, req_data.sample};
   assign quot_low = product[17:10];
   assign remainder = {1'b0, product[9:0]} + {3'd0, quot_low};
   assign tenths = (remainder >= ADC_FULL_CODE) ? quot_low + 8'd1 : quot_low;

   assign req_stall = stage_valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_data_in = stage_data_ff;
      if (take) begin
         stage_valid_in = 1'b1;
         stage_data_in.action = req_data.action;
         stage_data_in.ac_online = req_data.ac_online;
         stage_data_in.tenths = tenths;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_data_ff <= stage_data_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data = stage_data_ff;

endmodule

// File: rtl/ucmc_core.sv
// Phase sequencing, window averaging, mode choice and result register.
module ucmc_core #(
   parameter int SAMPLES_PER_WINDOW = 10
) (
   input  logic clock,
   input  logic reset,
   input  ucmc_pkg::cfg_type cfg,
   input  logic stage_valid,
   input  ucmc_pkg::stage_type stage_data,
   output logic advance,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ucmc_pkg::rsp_type rsp_data
);
   import ucmc_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES_PER_WINDOW + 1);
   localparam int SUM_W = TENTHS_W + IDX_W;
   localparam int SHIFT = SUM_W + IDX_W;
   localparam int RECIP = ((2 ** SHIFT) + SAMPLES_PER_WINDOW - 1) / SAMPLES_PER_WINDOW;
   localparam int PROD_W = SUM_W + SHIFT + 1;

   phase_type phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [1:0] mode_ff, mode_in;
   logic blink_ff, blink_in;
   logic relay_ff, relay_in;
   logic charge_ff, charge_in;
   logic led_fast_ff, led_fast_in;
   logic led_float_ff, led_float_in;
   logic [7:0] average_ff, average_in;
   logic average_valid_in;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic step;
   logic [7:0] count_inc;
   logic [IDX_W-1:0] index_inc;
   logic [SUM_W-1:0] sum_add;
   logic [PROD_W-1:0] product;
   logic [SUM_W:0] avg_wide;
   logic [7:0] avg_sat;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step = stage_valid && advance;

   assign count_inc = count_ff + 8'd1;
   assign index_inc = index_ff + IDX_W'(1);
   assign sum_add = sum_ff + SUM_W'(stage_data.tenths);
   assign product = PROD_W'(sum_add) * PROD_W'(RECIP);
   assign avg_wide = product[SHIFT+SUM_W:SHIFT];
   assign avg_sat = (|avg_wide[SUM_W:8]) ? 8'hFF : avg_wide[7:0];

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      index_in = index_ff;
      sum_in = sum_ff;
      mode_in = mode_ff;
      blink_in = blink_ff;
      relay_in = relay_ff;
      charge_in = charge_ff;
      led_fast_in = led_fast_ff;
      led_float_in = led_float_ff;
      average_in = average_ff;
      average_valid_in = 1'b0;
      if (step) begin
         case (stage_data.action)
            ACT_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  if (stage_data.ac_online) begin
                     phase_in = PH_DELAY;
                  end
               end else if (phase_ff == PH_DELAY) begin
                  count_in = count_inc;
                  if (count_inc >= cfg.startup_ticks) begin
                     phase_in = PH_RUN;
                     relay_in = 1'b1;
                  end
               end
            end
            ACT_POWER_FAIL: begin
               if (phase_ff == PH_RUN) begin
                  relay_in = 1'b0;
                  led_fast_in = 1'b0;
                  led_float_in = 1'b0;
                  phase_in = PH_HALT;
               end
            end
            ACT_SAMPLE: begin
               if (phase_ff == PH_RUN) begin
                  sum_in = sum_add;
                  index_in = index_inc;
                  if (mode_ff == MODE_DEAD) begin
                     blink_in = !blink_ff;
                     if (blink_ff) begin
                        led_fast_in = !led_fast_ff;
                        led_float_in = !led_float_ff;
                     end
                  end
                  if (index_inc == IDX_W'(SAMPLES_PER_WINDOW)) begin
                     average_in = avg_sat;
                     average_valid_in = 1'b1;
                     index_in = '0;
                     sum_in = '0;
                     if (avg_sat > cfg.float_enter_level) begin
                        led_fast_in = 1'b0;
                        led_float_in = 1'b1;
                        charge_in = 1'b1;
                        mode_in = MODE_FLOAT;
                     end else if (mode_ff == MODE_FLOAT && avg_sat >= cfg.float_hold_level) begin
                        led_fast_in = 1'b0;
                        led_float_in = 1'b1;
                        charge_in = 1'b1;
                     end else if (avg_sat < cfg.dead_level) begin
                        charge_in = 1'b1;
                        mode_in = MODE_DEAD;
                     end else begin
                        led_fast_in = 1'b1;
                        led_float_in = 1'b0;
                        charge_in = 1'b0;
                        mode_in = MODE_FAST;
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (step) begin
         rsp_data_in.relay_on = relay_in;
         rsp_data_in.charge_control = charge_in;
         rsp_data_in.led_fast = led_fast_in;
         rsp_data_in.led_float = led_float_in;
         rsp_data_in.mode = mode_in;
         rsp_data_in.average_tenths = average_in;
         rsp_data_in.average_valid = average_valid_in;
         rsp_data_in.phase = phase_code(phase_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         index_ff <= '0;
         sum_ff <= '0;
         mode_ff <= MODE_NONE;
         blink_ff <= 1'b0;
         relay_ff <= 1'b0;
         charge_ff <= 1'b1;
         led_fast_ff <= 1'b0;
         led_float_ff <= 1'b0;
         average_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         index_ff <= index_in;
         sum_ff <= sum_in;
         mode_ff <= mode_in;
         blink_ff <= blink_in;
         relay_ff <= relay_in;
         charge_ff <= charge_in;
         led_fast_ff <= led_fast_in;
         led_float_ff <= led_float_in;
         average_ff <= average_in;
         if (advance) begin
            rsp_valid_ff <= stage_valid;
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: rtl/ups_charge_mode_controller_top.sv
// UPS supervisor and battery charge-mode controller, top level.
// Takes timer ticks, power-fail edges and battery ADC samples, one item per
// cycle, and returns one status transfer per item: relay, charge control,
// LEDs, charge mode, last window average and phase. An item passes an input
// register, where the ADC code is scaled to tenths of a volt, and a result
// register, which holds and presents its status; a new item is taken
// every cycle while the result side does not stall. The window average
// divides by SAMPLES_PER_WINDOW through a reciprocal multiply. Write the
// configuration registers only while no transfer is in flight.
module ups_charge_mode_controller_top #(
   parameter int SAMPLES_PER_WINDOW = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ucmc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ucmc_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [ucmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ucmc_pkg::CFG_W-1:0] csr_write_data
);
   import ucmc_pkg::*;

   cfg_type cfg;
   logic advance;
   logic stage_valid;
   stage_type stage_data;

   ucmc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   ucmc_scale u_scale (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .full_scale_tenths(cfg.full_scale_tenths),
      .advance(advance),
      .stage_valid(stage_valid),
      .stage_data(stage_data)
   );

   ucmc_core #(
      .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .stage_valid(stage_valid),
      .stage_data(stage_data),
      .advance(advance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// File: rtl/ucmc_checker.sv
// Port-level assertions of the UPS charge-mode controller and their binding.
module ucmc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input ucmc_pkg::rsp_type rsp_data
);
   import ucmc_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.relay_on == (rsp_data.phase == PHASE_CODE_RUN))
      else $error("relay state disagrees with phase");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.average_valid |-> rsp_data.phase == PHASE_CODE_RUN)
      else $error("window average outside running phase");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.phase == PHASE_CODE_HALT
      |=> !rsp_valid || rsp_data.phase == PHASE_CODE_HALT)
      else $error("left halted phase without reset");

endmodule

bind ups_charge_mode_controller_top ucmc_checker u_checker (.*);
